>>> sv/mrr_pkg.sv
// ----------------------------------------------------------------------------
// Mask run package
// Shared constants and types of the mask run to rectangles block.
// ----------------------------------------------------------------------------
package mrr_pkg;

   localparam int MRR_MAX_WIDTH  = 4096;
   localparam int MRR_MAX_HEIGHT = 4096;

   localparam int SIZE_W   = 13;   // mask_width and mask_height registers
   localparam int OFFS_W   = 32;   // offset registers
   localparam int COORD_W  = 16;   // window coordinates and last positions
   localparam int INDEX_W  = 23;   // rectangle index
   localparam int CSR_IDX_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASK_WIDTH  = 8'd0,
      CSR_MASK_HEIGHT = 8'd1,
      CSR_OFFSET_X    = 8'd2,
      CSR_OFFSET_Y    = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0]       last_col;
      logic [COORD_W-1:0]       last_row;
      logic signed [OFFS_W-1:0] offset_x;
      logic signed [OFFS_W-1:0] offset_y;
   } cfg_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] rect_x;
      logic signed [COORD_W-1:0] rect_y;
      logic [SIZE_W-1:0]         run_width;
      logic [INDEX_W-1:0]        rect_index;
   } rect_type;

endpackage

>>> sv/mrr_if.sv
// ----------------------------------------------------------------------------
// Mask run channel interfaces
// Pixel request, rectangle response and register write channels.
// ----------------------------------------------------------------------------
interface mrr_req_if;
   logic valid;
   logic ready;
   logic pixel_active;

   modport source (output valid, output pixel_active, input ready);
   modport sink   (input valid, input pixel_active, output ready);
endinterface

interface mrr_rsp_if import mrr_pkg::*;;
   logic                      valid;
   logic                      ready;
   logic signed [COORD_W-1:0] rect_x;
   logic signed [COORD_W-1:0] rect_y;
   logic [SIZE_W-1:0]         run_width;
   logic [INDEX_W-1:0]        rect_index;

   modport source (output valid, output rect_x, output rect_y, output run_width,
                   output rect_index, input ready);
   modport sink   (input valid, input rect_x, input rect_y, input run_width,
                   input rect_index, output ready);
endinterface

interface mrr_csr_if import mrr_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [OFFS_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mask_run_to_rectangles_top.sv
// ----------------------------------------------------------------------------
// Mask run to rectangles
// Turns raster mask pixels into height-one rectangles, one per in-range run.
// ----------------------------------------------------------------------------
//   channel   direction  moves
//   req_bus   in         one mask pixel per request, raster order
//   rsp_bus   out        one rectangle per closed run that fits 16-bit range
//   csr_bus   in         register write: index and data, always ready
//
// A request can be accepted every clock while the skid entry is free. The
// scanner updates its position counters at the edge that accepts the request,
// and the rectangle goes at that same edge to the skid entry if the output is
// stalled, else to the output register and is on rsp_bus from the next cycle.
// Reset (synchronous) clears the position, the open run, the index and sets
// the registers to their reset values. A response stall is absorbed by one
// skid entry; req_bus.ready drops only while that entry is occupied.
// ----------------------------------------------------------------------------
module mask_run_to_rectangles_top import mrr_pkg::*; #(
   parameter int MAX_WIDTH  = MRR_MAX_WIDTH,
   parameter int MAX_HEIGHT = MRR_MAX_HEIGHT
) (
   input logic       clock,
   input logic       reset,
   mrr_req_if.sink   req_bus,
   mrr_rsp_if.source rsp_bus,
   mrr_csr_if.sink   csr_bus
);

   cfg_type  cfg;
   rect_type rect, rsp_data;
   logic     fire, emit, buf_ready;

   mrr_csr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_bus.valid),
      .wr_ready (csr_bus.ready),
      .wr_index (csr_bus.index),
      .wr_data  (csr_bus.data),
      .cfg      (cfg)
   );

   assign req_bus.ready = buf_ready;
   assign fire          = req_bus.valid && buf_ready;

   mrr_scan #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .fire         (fire),
      .pixel_active (req_bus.pixel_active),
      .emit         (emit),
      .rect         (rect)
   );

   mrr_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (emit),
      .push_data  (rect),
      .push_ready (buf_ready),
      .out_valid  (rsp_bus.valid),
      .out_ready  (rsp_bus.ready),
      .out_data   (rsp_data)
   );

   assign rsp_bus.rect_x     = rsp_data.rect_x;
   assign rsp_bus.rect_y     = rsp_data.rect_y;
   assign rsp_bus.run_width  = rsp_data.run_width;
   assign rsp_bus.rect_index = rsp_data.rect_index;

endmodule

>>> sv/mrr_csr.sv
// ----------------------------------------------------------------------------
// Mask run register file
// Holds the mask geometry, already clamped and turned into last positions.
// ----------------------------------------------------------------------------
module mrr_csr import mrr_pkg::*; #(
   parameter int MAX_WIDTH  = MRR_MAX_WIDTH,
   parameter int MAX_HEIGHT = MRR_MAX_HEIGHT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 wr_valid,
   output logic                 wr_ready,
   input  logic [CSR_IDX_W-1:0] wr_index,
   input  logic [OFFS_W-1:0]    wr_data,
   output cfg_type              cfg
);

   localparam logic [COORD_W:0] MAX_W_EXT = (COORD_W+1)'(MAX_WIDTH);
   localparam logic [COORD_W:0] MAX_H_EXT = (COORD_W+1)'(MAX_HEIGHT);

   cfg_type            cfg_ff, cfg_in;
   logic [COORD_W:0]   size_ext;
   logic [COORD_W-1:0] last_col_in, last_row_in;

   assign wr_ready = 1'b1;
   assign size_ext = (COORD_W+1)'(wr_data[SIZE_W-1:0]);

   // A zero size acts as one; larger sizes saturate at the maximum.
   always_comb begin
      if (size_ext == '0) begin
         last_col_in = '0;
         last_row_in = '0;
      end else begin
         last_col_in = (size_ext > MAX_W_EXT) ? COORD_W'(MAX_W_EXT - 1'b1)
                                               : COORD_W'(size_ext - 1'b1);
         last_row_in = (size_ext > MAX_H_EXT) ? COORD_W'(MAX_H_EXT - 1'b1)
                                               : COORD_W'(size_ext - 1'b1);
      end
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         case (wr_index)
            CSR_MASK_WIDTH:  cfg_in.last_col = last_col_in;
            CSR_MASK_HEIGHT: cfg_in.last_row = last_row_in;
            CSR_OFFSET_X:    cfg_in.offset_x = wr_data;
            CSR_OFFSET_Y:    cfg_in.offset_y = wr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/mrr_scan.sv
// ----------------------------------------------------------------------------
// Mask run scanner
// Tracks the raster position and closes runs of active pixels into rectangles.
// ----------------------------------------------------------------------------
module mrr_scan import mrr_pkg::*; #(
   parameter int MAX_WIDTH  = MRR_MAX_WIDTH,
   parameter int MAX_HEIGHT = MRR_MAX_HEIGHT
) (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  logic     fire,
   input  logic     pixel_active,
   output logic     emit,
   output rect_type rect
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SUM_W = OFFS_W + 2;

   logic [COL_W-1:0]   column_ff, column_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic               in_run_ff, in_run_in;
   logic [COL_W-1:0]   run_start_ff, run_start_in;
   logic [INDEX_W-1:0] count_ff, count_in;

   logic               row_end, last_row, close, in_range;
   logic [COL_W-1:0]   start_eff;
   logic [COL_W:0]     width;
   logic signed [SUM_W-1:0] rx, ry;

   assign row_end  = COORD_W'(column_ff) >= cfg.last_col;
   assign last_row = COORD_W'(row_ff) >= cfg.last_row;

   // An active pixel with no open run starts one at the current column.
   assign start_eff = (pixel_active && !in_run_ff) ? column_ff : run_start_ff;
   assign close     = pixel_active ? row_end : in_run_ff;
   assign width     = (COL_W+1)'(column_ff) + (COL_W+1)'(pixel_active)
                      - (COL_W+1)'(start_eff);

   assign rx = $signed(SUM_W'(start_eff)) + SUM_W'(cfg.offset_x);
   assign ry = $signed(SUM_W'(row_ff)) + SUM_W'(cfg.offset_y);

   // The sum fits 16 signed bits when its bits above bit 14 all agree.
   assign in_range = ((rx[SUM_W-1:COORD_W-1] == '0) || (rx[SUM_W-1:COORD_W-1] == '1))
                  && ((ry[SUM_W-1:COORD_W-1] == '0) || (ry[SUM_W-1:COORD_W-1] == '1));

   assign emit = fire && close && in_range;

   assign rect.rect_x     = rx[COORD_W-1:0];
   assign rect.rect_y     = ry[COORD_W-1:0];
   assign rect.run_width  = SIZE_W'(width);
   assign rect.rect_index = count_ff;

   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      in_run_in    = in_run_ff;
      run_start_in = run_start_ff;
      count_in     = count_ff;
      if (fire) begin
         in_run_in    = pixel_active && !row_end;
         run_start_in = start_eff;
         if (emit) begin
            count_in = count_ff + 1'b1;
         end
         if (row_end) begin
            column_in = '0;
            if (last_row) begin
               row_in   = '0;
               count_in = '0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            column_in = column_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff    <= '0;
         row_ff       <= '0;
         in_run_ff    <= 1'b0;
         run_start_ff <= '0;
         count_ff     <= '0;
      end else begin
         column_ff    <= column_in;
         row_ff       <= row_in;
         in_run_ff    <= in_run_in;
         run_start_ff <= run_start_in;
         count_ff     <= count_in;
      end
   end

endmodule

>>> sv/mrr_out_buf.sv
// ----------------------------------------------------------------------------
// Mask run output buffer
// Output register with one skid entry that takes one rectangle under a stall.
// ----------------------------------------------------------------------------
module mrr_out_buf import mrr_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  rect_type push_data,
   output logic     push_ready,
   output logic     out_valid,
   input  logic     out_ready,
   output rect_type out_data
);

   logic     out_valid_ff, out_valid_in;
   logic     skid_valid_ff, skid_valid_in;
   rect_type out_data_ff, out_data_in;
   rect_type skid_data_ff, skid_data_in;

   // A push arrives only while the skid entry is free.
   assign push_ready = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || out_ready) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_data_ff;

endmodule
